// ===== src/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg: shared types and constants of the quaternion arithmetic unit
// Value format, mode codes, square-root sizing and normalise result record.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int VAL_W    = 18;
  localparam int VAL_MAX  = 131071;
  localparam int VAL_MIN  = -131072;

  // squared length of a quaternion of VAL_W-bit values is at most 2^36
  localparam int S_W      = 37;
  localparam int L_W      = 19;
  localparam int SQ_STEPS = 19;

  // register stages through the normalise unit: root, divide setup,
  // one stage per quotient bit, output
  localparam int NORM_LAT = SQ_STEPS + 1 + VAL_W + 1 + 1;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_MUL  = 3'd1,
    MODE_CONJ = 3'd2,
    MODE_NORM = 3'd3,
    MODE_MAT  = 3'd4
  } mode_e;

  typedef struct packed {
    val_t [3:0] q;
    logic       sat;
    logic       zl;
  } norm_res_t;

endpackage

// ===== src/qau_norm.sv =====
// ----------------------------------------------------------------------------
// qau_norm: pipelined normalise unit
// Integer square root of the squared length, one result bit per stage, then
// four restoring dividers, one quotient bit per stage. Fixed pipeline depth; all stages hold while en is low.
// ----------------------------------------------------------------------------
module qau_norm import qau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [S_W-1:0] s,
  input  val_t           a [4],
  output norm_res_t      res
);

  localparam int D_W = VAL_W + FRAC_BITS;
  localparam int C_W = (D_W > L_W + VAL_W) ? D_W : L_W + VAL_W;
  localparam bit ONE_OK = (2 * FRAC_BITS < S_W);
  localparam logic [S_W-1:0] ONE_S = ONE_OK ? (S_W'(1) << (2 * FRAC_BITS)) : '0;
  localparam int SQN = SQ_STEPS + 1;
  localparam int DVN = VAL_W + 1;

  function automatic logic [2*S_W-1:0] sq_step(input logic [S_W-1:0] n,
                                               input logic [S_W-1:0] r,
                                               input int k);
    logic [S_W:0] bitv;
    logic [S_W:0] t;
    bitv = (S_W+1)'(1) << (S_W - 1 - 2 * k);
    t = {1'b0, r} + bitv;
    if ({1'b0, n} >= t) return {n - t[S_W-1:0], (r >> 1) + bitv[S_W-1:0]};
    else return {n, r >> 1};
  endfunction

  function automatic logic [L_W:0] dv_step(input logic [L_W-1:0] r, input logic b,
                                           input logic [L_W-1:0] d);
    logic [L_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, L_W'(t - {1'b0, d})};
    else return {1'b0, t[L_W-1:0]};
  endfunction

  // square root stages
  logic [S_W-1:0] sn_r    [SQN];
  logic [S_W-1:0] sres_r  [SQN];
  val_t           sa_r    [SQN][4];
  logic           szl_r   [SQN];
  logic           spass_r [SQN];

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0]    <= s;
      sres_r[0]  <= '0;
      sa_r[0]    <= a;
      szl_r[0]   <= (s == '0);
      spass_r[0] <= ONE_OK && (s == ONE_S);
      for (int k = 0; k < SQ_STEPS; k++) begin
        {sn_r[k+1], sres_r[k+1]} <= sq_step(sn_r[k], sres_r[k], k);
        sa_r[k+1]    <= sa_r[k];
        szl_r[k+1]   <= szl_r[k];
        spass_r[k+1] <= spass_r[k];
      end
    end
  end

  // divide setup: dividend is |c| << FRAC_BITS plus half the length
  logic [L_W-1:0]   lval;
  logic             su_neg  [4];
  logic [VAL_W-1:0] su_abs  [4];
  logic [D_W-1:0]   su_dd   [4];
  logic             su_ovf  [4];
  logic [L_W-1:0]   su_rem  [4];

  always_comb begin
    lval = sres_r[SQ_STEPS][L_W-1:0];
    for (int j = 0; j < 4; j++) begin
      su_neg[j] = sa_r[SQ_STEPS][j][VAL_W-1];
      su_abs[j] = su_neg[j] ? (~sa_r[SQ_STEPS][j] + 1'b1) : sa_r[SQ_STEPS][j];
      su_dd[j]  = (D_W'(su_abs[j]) << FRAC_BITS) + D_W'(lval >> 1);
      // quotient of 2^VAL_W or more clamps either way
      su_ovf[j] = C_W'(su_dd[j]) >= (C_W'(lval) << VAL_W);
      su_rem[j] = L_W'(su_dd[j] >> VAL_W);
    end
  end

  // divide stages
  logic [L_W-1:0]   rem_r  [DVN][4];
  logic [VAL_W-1:0] low_r  [DVN][4];
  logic [VAL_W-1:0] quo_r  [DVN][4];
  logic             ovf_r  [DVN][4];
  logic             neg_r  [DVN][4];
  logic [L_W-1:0]   dl_r   [DVN];
  val_t             da_r   [DVN][4];
  logic             dzl_r  [DVN];
  logic             dpass_r[DVN];
  logic [L_W:0]     stp    [VAL_W][4];

  always_comb begin
    for (int k = 0; k < VAL_W; k++) begin
      for (int j = 0; j < 4; j++) begin
        stp[k][j] = dv_step(rem_r[k][j], low_r[k][j][VAL_W-1-k], dl_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        rem_r[0][j] <= su_rem[j];
        low_r[0][j] <= su_dd[j][VAL_W-1:0];
        quo_r[0][j] <= '0;
        ovf_r[0][j] <= su_ovf[j];
        neg_r[0][j] <= su_neg[j];
      end
      dl_r[0]    <= lval;
      da_r[0]    <= sa_r[SQ_STEPS];
      dzl_r[0]   <= szl_r[SQ_STEPS];
      dpass_r[0] <= spass_r[SQ_STEPS];
      for (int k = 0; k < VAL_W; k++) begin
        for (int j = 0; j < 4; j++) begin
          rem_r[k+1][j] <= stp[k][j][L_W-1:0];
          low_r[k+1][j] <= low_r[k][j];
          quo_r[k+1][j] <= {quo_r[k][j][VAL_W-2:0], stp[k][j][L_W]};
          ovf_r[k+1][j] <= ovf_r[k][j];
          neg_r[k+1][j] <= neg_r[k][j];
        end
        dl_r[k+1]    <= dl_r[k];
        da_r[k+1]    <= da_r[k];
        dzl_r[k+1]   <= dzl_r[k];
        dpass_r[k+1] <= dpass_r[k];
      end
    end
  end

  // sign, clamp and the zero-length / unit-length overrides
  norm_res_t        res_nxt;
  logic [VAL_W-1:0] fq  [4];
  logic             fsat[4];

  always_comb begin
    res_nxt = '0;
    for (int j = 0; j < 4; j++) begin
      fq[j]   = quo_r[VAL_W][j];
      fsat[j] = ovf_r[VAL_W][j] ||
                (!neg_r[VAL_W][j] && fq[j] > VAL_W'(VAL_MAX)) ||
                (neg_r[VAL_W][j] && fq[j] > (VAL_W'(1) << (VAL_W - 1)));
      if (fsat[j]) res_nxt.q[j] = neg_r[VAL_W][j] ? VAL_W'(VAL_MIN) : VAL_W'(VAL_MAX);
      else res_nxt.q[j] = neg_r[VAL_W][j] ? (~fq[j] + 1'b1) : fq[j];
      res_nxt.sat = res_nxt.sat | fsat[j];
    end
    if (dzl_r[VAL_W]) begin
      res_nxt = '0;
      res_nxt.zl = 1'b1;
    end else if (dpass_r[VAL_W]) begin
      for (int j = 0; j < 4; j++) res_nxt.q[j] = da_r[VAL_W][j];
      res_nxt.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_nxt;
  end

endmodule

// ===== src/quaternion_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit: Q2.16 quaternion add, multiply, conjugate,
// normalise and rotation matrix
// Pipelined datapath with a normalise unit and a row-sequencing output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry a mode and two quaternions a and b on in_* with a
//   valid/ready handshake. Results leave on out_* with valid/ready. Each
//   request gives one result, except the rotation matrix mode, which gives
//   three rows (row_index 0..2, last set on row 2).
//   Every mode passes through the same registers to the first result: input,
//   products and sums, a delay line as deep as the normalise unit (one
//   square-root bit and one quotient bit per stage), and the output register.
//   Throughput is one request per cycle while the receiver takes each result;
//   a matrix request holds the output register until its three rows are sent,
//   and the pipeline holds while rows are sent.
//   Reset clears all valid bits and the row counter; no result is pending.
//   When the receiver stalls, the whole pipeline holds in place and
//   in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_mode,
  input  logic signed [VAL_W-1:0] in_a_w,
  input  logic signed [VAL_W-1:0] in_a_x,
  input  logic signed [VAL_W-1:0] in_a_y,
  input  logic signed [VAL_W-1:0] in_a_z,
  input  logic signed [VAL_W-1:0] in_b_w,
  input  logic signed [VAL_W-1:0] in_b_x,
  input  logic signed [VAL_W-1:0] in_b_y,
  input  logic signed [VAL_W-1:0] in_b_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [VAL_W-1:0] out_val0,
  output logic signed [VAL_W-1:0] out_val1,
  output logic signed [VAL_W-1:0] out_val2,
  output logic signed [VAL_W-1:0] out_val3,
  output logic [1:0]        out_row_index,
  output logic              out_last,
  output logic              out_saturated,
  output logic              out_zero_length
);

  localparam int W   = (2 * FRAC_BITS + 3 > 40) ? 2 * FRAC_BITS + 3 : 40;
  localparam int P_W = 2 * VAL_W;
  localparam logic signed [W-1:0] ONE_W = W'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic [2:0] mode;
    val_t [3:0] q;
    logic       qsat;
    val_t [8:0] m;
    logic [2:0] msat;
  } rec_t;

  // round to nearest, ties toward plus infinity, then clamp
  function automatic logic [VAL_W:0] rnd_clamp(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = (v + (W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > W'(VAL_MAX)) return {1'b1, VAL_W'(VAL_MAX)};
    else if (t < W'(VAL_MIN)) return {1'b1, VAL_W'(VAL_MIN)};
    else return {1'b0, t[VAL_W-1:0]};
  endfunction

  function automatic logic [VAL_W:0] clamp19(input logic signed [VAL_W:0] v);
    if (v > (VAL_W+1)'(VAL_MAX)) return {1'b1, VAL_W'(VAL_MAX)};
    else if (v < (VAL_W+1)'(VAL_MIN)) return {1'b1, VAL_W'(VAL_MIN)};
    else return {1'b0, v[VAL_W-1:0]};
  endfunction

  logic en;
  logic ov_r;
  logic omat_r;
  logic [1:0] row_r;

  assign out_last = !omat_r || (row_r == 2'd2);
  assign en       = !ov_r || (out_ready && out_last);
  assign in_ready = en;

  // ---------------- stage 1: input registers
  logic       v1_r;
  logic [2:0] mode1_r;
  val_t       a1_r [4];
  val_t       b1_r [4];
  logic       use_a;

  // normalise and matrix use the products of a with itself
  assign use_a = (in_mode == MODE_NORM) || (in_mode == MODE_MAT);

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= in_mode;
      a1_r[0] <= in_a_w;
      a1_r[1] <= in_a_x;
      a1_r[2] <= in_a_y;
      a1_r[3] <= in_a_z;
      b1_r[0] <= use_a ? in_a_w : in_b_w;
      b1_r[1] <= use_a ? in_a_x : in_b_x;
      b1_r[2] <= use_a ? in_a_y : in_b_y;
      b1_r[3] <= use_a ? in_a_z : in_b_z;
    end
  end

  // ---------------- stage 2: products, add and conjugate
  logic                    v2_r;
  logic [2:0]              mode2_r;
  val_t                    a2_r [4];
  logic signed [P_W-1:0]   prod2_r [4][4];
  val_t                    simp2_nxt [4];
  val_t                    simp2_r [4];
  logic                    ssat2_nxt;
  logic                    ssat2_r;
  logic [VAL_W:0]          c19 [4];

  always_comb begin
    ssat2_nxt = 1'b0;
    for (int j = 0; j < 4; j++) begin
      c19[j] = '0;
      simp2_nxt[j] = '0;
    end
    case (mode1_r)
      MODE_ADD: begin
        for (int j = 0; j < 4; j++) begin
          c19[j] = clamp19({a1_r[j][VAL_W-1], a1_r[j]} + {b1_r[j][VAL_W-1], b1_r[j]});
          simp2_nxt[j] = c19[j][VAL_W-1:0];
          ssat2_nxt = ssat2_nxt | c19[j][VAL_W];
        end
      end
      MODE_CONJ: begin
        simp2_nxt[0] = a1_r[0];
        for (int j = 1; j < 4; j++) begin
          c19[j] = clamp19(-{a1_r[j][VAL_W-1], a1_r[j]});
          simp2_nxt[j] = c19[j][VAL_W-1:0];
          ssat2_nxt = ssat2_nxt | c19[j][VAL_W];
        end
      end
      default: ssat2_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r <= mode1_r;
      a2_r    <= a1_r;
      simp2_r <= simp2_nxt;
      ssat2_r <= ssat2_nxt;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) prod2_r[i][j] <= a1_r[i] * b1_r[j];
      end
    end
  end

  // ---------------- stage 3: product sums
  logic                  v3_r;
  logic [2:0]            mode3_r;
  val_t                  a3_r [4];
  val_t                  simp3_r [4];
  logic                  ssat3_r;
  logic signed [W-1:0]   e [4][4];
  logic signed [W-1:0]   ham3_nxt [4];
  logic signed [W-1:0]   mat3_nxt [9];
  logic signed [W-1:0]   ssum;
  logic signed [W-1:0]   ham3_r [4];
  logic signed [W-1:0]   mat3_r [9];
  logic [S_W-1:0]        s3_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) e[i][j] = W'(prod2_r[i][j]);
    end
    ham3_nxt[0] = e[0][0] - e[1][1] - e[2][2] - e[3][3];
    ham3_nxt[1] = e[0][1] + e[1][0] + e[2][3] - e[3][2];
    ham3_nxt[2] = e[0][2] - e[1][3] + e[2][0] + e[3][1];
    ham3_nxt[3] = e[0][3] + e[1][2] - e[2][1] + e[3][0];
    // w=0 x=1 y=2 z=3, products of a with itself
    mat3_nxt[0] = ONE_W - (e[2][2] <<< 1) - (e[3][3] <<< 1);
    mat3_nxt[1] = (e[1][2] <<< 1) - (e[0][3] <<< 1);
    mat3_nxt[2] = (e[1][3] <<< 1) + (e[0][2] <<< 1);
    mat3_nxt[3] = (e[1][2] <<< 1) + (e[0][3] <<< 1);
    mat3_nxt[4] = ONE_W - (e[1][1] <<< 1) - (e[3][3] <<< 1);
    mat3_nxt[5] = (e[2][3] <<< 1) - (e[0][1] <<< 1);
    mat3_nxt[6] = (e[1][3] <<< 1) - (e[0][2] <<< 1);
    mat3_nxt[7] = (e[2][3] <<< 1) + (e[0][1] <<< 1);
    mat3_nxt[8] = ONE_W - (e[1][1] <<< 1) - (e[2][2] <<< 1);
    ssum = e[0][0] + e[1][1] + e[2][2] + e[3][3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode3_r <= mode2_r;
      a3_r    <= a2_r;
      simp3_r <= simp2_r;
      ssat3_r <= ssat2_r;
      ham3_r  <= ham3_nxt;
      mat3_r  <= mat3_nxt;
      s3_r    <= ssum[S_W-1:0];
    end
  end

  // ---------------- stage 4: rounding and clamping, then delay line
  rec_t           rec_nxt;
  logic [VAL_W:0] hr [4];
  logic [VAL_W:0] mr [9];

  always_comb begin
    rec_nxt = '0;
    rec_nxt.mode = mode3_r;
    for (int j = 0; j < 4; j++) hr[j] = rnd_clamp(ham3_r[j]);
    for (int k = 0; k < 9; k++) begin
      mr[k] = rnd_clamp(mat3_r[k]);
      rec_nxt.m[k] = mr[k][VAL_W-1:0];
    end
    for (int r = 0; r < 3; r++) begin
      rec_nxt.msat[r] = mr[3*r][VAL_W] | mr[3*r+1][VAL_W] | mr[3*r+2][VAL_W];
    end
    case (mode3_r)
      MODE_MUL: begin
        for (int j = 0; j < 4; j++) begin
          rec_nxt.q[j] = hr[j][VAL_W-1:0];
          rec_nxt.qsat = rec_nxt.qsat | hr[j][VAL_W];
        end
      end
      MODE_ADD, MODE_CONJ: begin
        for (int j = 0; j < 4; j++) rec_nxt.q[j] = simp3_r[j];
        rec_nxt.qsat = ssat3_r;
      end
      default: rec_nxt.qsat = 1'b0;
    endcase
  end

  rec_t      rec_r [NORM_LAT];
  logic      vl_r  [NORM_LAT];
  norm_res_t nres;

  qau_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk (clk),
    .en  (en),
    .s   (s3_r),
    .a   (a3_r),
    .res (nres)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rec_r[0] <= rec_nxt;
      for (int k = 1; k < NORM_LAT; k++) rec_r[k] <= rec_r[k-1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      for (int k = 0; k < NORM_LAT; k++) vl_r[k] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vl_r[0] <= v3_r;
      for (int k = 1; k < NORM_LAT; k++) vl_r[k] <= vl_r[k-1];
    end
  end

  // ---------------- output register, steps through matrix rows
  val_t       oq_r [4];
  logic       oqsat_r;
  logic       ozl_r;
  val_t       om_r [9];
  logic [2:0] omsat_r;
  rec_t       rend;

  assign rend = rec_r[NORM_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      row_r <= 2'd0;
    end else if (en) begin
      ov_r  <= vl_r[NORM_LAT-1];
      row_r <= 2'd0;
    end else if (ov_r && out_ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      omat_r  <= (rend.mode == MODE_MAT);
      omsat_r <= rend.msat;
      for (int k = 0; k < 9; k++) om_r[k] <= rend.m[k];
      if (rend.mode == MODE_NORM) begin
        for (int j = 0; j < 4; j++) oq_r[j] <= nres.q[j];
        oqsat_r <= nres.sat;
        ozl_r   <= nres.zl;
      end else begin
        for (int j = 0; j < 4; j++) oq_r[j] <= rend.q[j];
        oqsat_r <= rend.qsat;
        ozl_r   <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    if (omat_r) begin
      out_val3        = '0;
      out_row_index   = row_r;
      out_zero_length = 1'b0;
      case (row_r)
        2'd0: begin
          out_val0      = om_r[0];
          out_val1      = om_r[1];
          out_val2      = om_r[2];
          out_saturated = omsat_r[0];
        end
        2'd1: begin
          out_val0      = om_r[3];
          out_val1      = om_r[4];
          out_val2      = om_r[5];
          out_saturated = omsat_r[1];
        end
        default: begin
          out_val0      = om_r[6];
          out_val1      = om_r[7];
          out_val2      = om_r[8];
          out_saturated = omsat_r[2];
        end
      endcase
    end else begin
      out_val0        = oq_r[0];
      out_val1        = oq_r[1];
      out_val2        = oq_r[2];
      out_val3        = oq_r[3];
      out_row_index   = 2'd0;
      out_saturated   = oqsat_r;
      out_zero_length = ozl_r;
    end
  end

`ifndef ASSERT_OFF
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_index != 2'd3)
    else $error("row index out of range");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_row_index == $past(out_row_index) + 2'd1)
    else $error("matrix row did not advance");

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_val0 == '0 && out_val1 == '0 && out_val2 == '0 && out_val3 == '0 &&
      !out_saturated && out_last)
    else $error("zero length result not cleared");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !(out_ready && out_last))
    else $error("input stalled without a held result");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the quaternion arithmetic unit
// Sends directed and random requests in every mode, predicts each result
// row in fixed point and compares it with the unit's output, under random
// stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import qau_pkg::*;

  localparam int FB = 16;
  localparam int DRAIN = 200;
  localparam int WD_LIMIT = 20000;

  typedef struct {
    logic signed [17:0] v [4];
    logic [1:0] row;
    logic last, sat, zl;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] in_mode = 0;
  logic signed [17:0] in_a_w = 0, in_a_x = 0, in_a_y = 0, in_a_z = 0;
  logic signed [17:0] in_b_w = 0, in_b_x = 0, in_b_y = 0, in_b_z = 0;
  logic signed [17:0] out_val0, out_val1, out_val2, out_val3;
  logic [1:0] out_row_index;
  logic out_last, out_saturated, out_zero_length;

  row_t pending_rows [$];
  int errors = 0, wd = 0, n_sent = 0, n_rows = 0;
  bit calm = 0;
  int mode_seen [8];

  always #1 clk = ~clk;

  quaternion_arithmetic_unit #(.FRAC_BITS(FB)) dut (.*);

  function automatic longint rnd_shift(longint v);
    longint u;
    u = v + (longint'(1) << (FB - 1));
    return u >>> FB;  // arithmetic shift floors, ties go up
  endfunction

  function automatic longint clip(longint v, inout logic sat);
    if (v > VAL_MAX) begin sat = 1; return VAL_MAX; end
    if (v < VAL_MIN) begin sat = 1; return VAL_MIN; end
    return v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin n = n - (r + b); r = (r >> 1) + b; end
      else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic predict_rows(logic [2:0] md, longint a[4], longint b[4]);
    row_t r;
    longint p[4], m[3][3], s, len, mag, q, one;
    r.row = 0; r.last = 1; r.sat = 0; r.zl = 0;
    for (int j = 0; j < 4; j++) r.v[j] = 0;
    case (md)
      MODE_ADD: for (int j = 0; j < 4; j++) r.v[j] = clip(a[j] + b[j], r.sat);
      MODE_MUL: begin
        p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
        p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
        p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
        for (int j = 0; j < 4; j++) r.v[j] = clip(rnd_shift(p[j]), r.sat);
      end
      MODE_CONJ: begin
        r.v[0] = a[0];
        for (int j = 1; j < 4; j++) r.v[j] = clip(-a[j], r.sat);
      end
      MODE_NORM: begin
        s = 0;
        for (int j = 0; j < 4; j++) s += a[j] * a[j];
        if (s == 0) r.zl = 1;
        else if (s == (longint'(1) << (2 * FB)))
          for (int j = 0; j < 4; j++) r.v[j] = a[j];
        else begin
          len = int_sqrt(s);
          for (int j = 0; j < 4; j++) begin
            mag = (a[j] < 0 ? -a[j] : a[j]) << FB;
            q = (mag + len / 2) / len;
            r.v[j] = clip(a[j] < 0 ? -q : q, r.sat);
          end
        end
      end
      MODE_MAT: begin
        one = longint'(1) << (2 * FB);
        m[0][0] = one - 2*a[2]*a[2] - 2*a[3]*a[3];
        m[0][1] = 2*a[1]*a[2] - 2*a[0]*a[3];
        m[0][2] = 2*a[1]*a[3] + 2*a[0]*a[2];
        m[1][0] = 2*a[1]*a[2] + 2*a[0]*a[3];
        m[1][1] = one - 2*a[1]*a[1] - 2*a[3]*a[3];
        m[1][2] = 2*a[2]*a[3] - 2*a[0]*a[1];
        m[2][0] = 2*a[1]*a[3] - 2*a[0]*a[2];
        m[2][1] = 2*a[2]*a[3] + 2*a[0]*a[1];
        m[2][2] = one - 2*a[1]*a[1] - 2*a[2]*a[2];
        for (int k = 0; k < 3; k++) begin
          r.sat = 0;
          for (int j = 0; j < 3; j++) r.v[j] = clip(rnd_shift(m[k][j]), r.sat);
          r.v[3] = 0;
          r.row = k;
          r.last = (k == 2);
          pending_rows.push_back(r);
        end
        return;
      end
      default: ;
    endcase
    pending_rows.push_back(r);
  endtask

  // valid drops only during idle cycles, so back to back requests keep it high
  task automatic send_req(logic [2:0] md, logic signed [17:0] q[8]);
    longint a[4], b[4];
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_mode <= md;
    in_a_w <= q[0]; in_a_x <= q[1]; in_a_y <= q[2]; in_a_z <= q[3];
    in_b_w <= q[4]; in_b_x <= q[5]; in_b_y <= q[6]; in_b_z <= q[7];
    for (int j = 0; j < 4; j++) begin a[j] = q[j]; b[j] = q[4 + j]; end
    predict_rows(md, a, b);
    mode_seen[md]++;
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [17:0] rnd_val();
    case ($urandom_range(5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return $urandom_range(131072) - 65536;   // within unit range
      3: return $urandom_range(512) - 256;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [17:0] q[8];
    logic signed [17:0] ext [4] = '{VAL_MAX, VAL_MIN, 0, 18'sh10000};
    for (int md = 0; md < 8; md++)
      for (int e = 0; e < 2; e++) begin
        for (int j = 0; j < 8; j++) q[j] = ext[(j + e) % 4];
        send_req(md, q);
      end
    q = '{default: 0};
    send_req(MODE_NORM, q);             // zero length
    q[0] = 18'sh10000;
    send_req(MODE_NORM, q);             // exactly unit length
    send_req(MODE_MAT, q);              // identity rotation
    q = '{default: VAL_MIN};
    send_req(MODE_NORM, q);
    send_req(MODE_MUL, q);
    q = '{default: 1};
    send_req(MODE_NORM, q);
    send_req(MODE_CONJ, q);
  endtask

  task automatic test_random();
    logic signed [17:0] q[8];
    for (int i = 0; i < 180; i++) begin
      calm = (i >= 80 && i < 120);
      for (int j = 0; j < 8; j++) q[j] = rnd_val();
      send_req($urandom_range(99) < 94 ? $urandom_range(4) : $urandom_range(7), q);
    end
    calm = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && (calm || $urandom_range(99) >= 23)) out_ready <= 1;
    else out_ready <= 0;
  end

  always @(posedge clk) begin
    row_t e;
    if ((in_valid && in_ready) || (out_valid && out_ready)) wd <= 0;
    else wd <= wd + 1;
    if (wd > WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      n_rows++;
      if (pending_rows.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = pending_rows.pop_front();
        if (out_val0 !== e.v[0]) begin
          $error("val0 exp %0d got %0d", e.v[0], out_val0); errors++; end
        if (out_val1 !== e.v[1]) begin
          $error("val1 exp %0d got %0d", e.v[1], out_val1); errors++; end
        if (out_val2 !== e.v[2]) begin
          $error("val2 exp %0d got %0d", e.v[2], out_val2); errors++; end
        if (out_val3 !== e.v[3]) begin
          $error("val3 exp %0d got %0d", e.v[3], out_val3); errors++; end
        if (out_row_index !== e.row) begin
          $error("row_index exp %0d got %0d", e.row, out_row_index); errors++; end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++; end
        if (out_saturated !== e.sat) begin
          $error("saturated exp %0d got %0d", e.sat, out_saturated); errors++; end
        if (out_zero_length !== e.zl) begin
          $error("zero_length exp %0d got %0d", e.zl, out_zero_length); errors++; end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_rows.size() != 0) errors++;
    $display("sent %0d requests, checked %0d rows", n_sent, n_rows);
    $display("per mode: add %0d mul %0d conj %0d norm %0d mat %0d", mode_seen[0],
             mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
